// ===== rtl/life_grid_generation_step_assert.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("life grid check failed");

// The consequent must hold in the cycle after the antecedent.
`define LGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("life grid check failed");

`endif

// ===== rtl/lgs_pkg.sv =====
package lgs_pkg;

	// Default storage edge length.
	localparam int MAX_SIZE_DEF = 64;

	// Field widths of the streams.
	localparam int OP_W    = 2;
	localparam int COORD_W = 6;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 8;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int GSIZE_W    = 7;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_EDGES = 1'b1;
	localparam logic [GSIZE_W-1:0]   GRID_SIZE_RST  = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_CLEAR   = 2'd3
	} lgs_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_GEN_TOP,
		ST_GEN_MID,
		ST_GEN_ROW,
		ST_DONE
	} lgs_state_t;

endpackage

// ===== rtl/life_grid_generation_step.sv =====
// Channel   | Direction | Signals                      | Contents
// ----------+-----------+------------------------------+-------------------------------
// s_*       | in        | s_tvalid, s_tready, s_tdata  | op, col, row, cell_in
// m_*       | out       | m_tvalid, m_tready, m_tdata  | cell_out
// cfg_*     | in        | cfg_we, cfg_index, cfg_data  | grid_size, wrap_edges
//
// A write or read issues the row read at acceptance, the next cycle modifies and writes
// the row back, and ST_DONE loads the result. An advance for an active edge length N
// reads the last row at acceptance, ST_GEN_TOP and ST_GEN_MID prime the row window, then
// one row is computed and written back per cycle. Reset, a clear and any grid_size write
// mark all rows dead at once by their valid bits. A new transaction is accepted the cycle
// after a result is loaded; only a full output register that is not taken stalls.
module life_grid_generation_step #(
	parameter int MAX_SIZE = lgs_pkg::MAX_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// From bit 0: op[1:0], col[7:2], row[13:8], cell_in[14], zero[15].
	input  logic [lgs_pkg::IN_W-1:0]        s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// From bit 0: cell_out[0], zero[7:1].
	output logic [lgs_pkg::OUT_W-1:0]       m_tdata,
	input  logic                            cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lgs_pkg::*;

`include "life_grid_generation_step_assert.svh"

	localparam int NW = $clog2(MAX_SIZE + 1);
	localparam int AW = $clog2(MAX_SIZE);
	localparam int SW = (NW > GSIZE_W) ? NW : GSIZE_W;
	localparam int CW = (NW > COORD_W) ? NW : COORD_W;

	// Input fields.
	lgs_op_t              in_op;
	logic [COORD_W-1:0]   in_col;
	logic [COORD_W-1:0]   in_row;
	logic                 in_cell;
	logic                 in_acc;

	assign in_op   = lgs_op_t'(s_tdata[1:0]);
	assign in_col  = s_tdata[7:2];
	assign in_row  = s_tdata[13:8];
	assign in_cell = s_tdata[14];
	assign in_acc  = s_tvalid && s_tready;

	// Configuration registers.
	logic [GSIZE_W-1:0] grid_size_q;
	logic               wrap_q;
	logic               size_wr;

	assign size_wr = cfg_we && (cfg_index == REG_GRID_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= GRID_SIZE_RST;
			wrap_q      <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SIZE:  grid_size_q <= cfg_data[GSIZE_W-1:0];
				REG_WRAP_EDGES: wrap_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Active edge length: the register, limited to the storage size.
	logic [SW-1:0] gs_ext;
	logic [NW-1:0] n_act;
	logic [NW-1:0] n_m1;

	assign gs_ext = SW'(grid_size_q);
	assign n_act  = (gs_ext > SW'(MAX_SIZE)) ? NW'(MAX_SIZE) : NW'(gs_ext);
	assign n_m1   = n_act - NW'(1);

	// Item registers, captured at acceptance.
	lgs_state_t     state_q, state_d;
	lgs_op_t        op_q;
	logic [AW-1:0]  col_q;
	logic [AW-1:0]  row_q;
	logic           cell_in_q;
	logic           hit_q;
	logic           res_q;
	logic           in_hit;

	assign in_hit = (CW'(in_col) < CW'(n_act)) && (CW'(in_row) < CW'(n_act));

	// Row memory: one write and one registered read per cycle. Each row has a
	// valid bit; a row that is not valid reads as all dead.
	logic [MAX_SIZE-1:0] grid_mem_q [MAX_SIZE];
	logic [MAX_SIZE-1:0] vld_q;
	logic [MAX_SIZE-1:0] mem_rd_s1;
	logic                mem_vld_s1;
	logic [MAX_SIZE-1:0] rd_row;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                mem_we;
	logic [AW-1:0]       wr_addr;
	logic [MAX_SIZE-1:0] wr_data;
	logic                clr_all;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1  <= grid_mem_q[rd_addr];
			mem_vld_s1 <= vld_q[rd_addr];
		end
	end

	assign rd_row = mem_vld_s1 ? mem_rd_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clr_all) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Generation window: the old rows above, at and below the row being computed.
	// The old first row is kept aside because it is rewritten before the last
	// row needs it as its wrapped lower neighbour.
	logic [MAX_SIZE-1:0] up_q, mid_q, first_q;
	logic [MAX_SIZE-1:0] dn_row;
	logic [MAX_SIZE-1:0] new_row;
	logic                last_row;
	logic                more_rows;

	assign last_row  = (NW'(row_q) == n_m1);
	assign more_rows = ((NW + 1)'(row_q) + (NW + 1)'(2)) < (NW + 1)'(n_act);
	assign dn_row    = last_row ? (wrap_q ? first_q : '0) : rd_row;

	lgs_row_next #(
		.MAX_SIZE (MAX_SIZE)
	) u_row_next (
		.up   (up_q),
		.mid  (mid_q),
		.dn   (dn_row),
		.size (n_act),
		.wrap (wrap_q),
		.nxt  (new_row)
	);

	// Output register.
	logic m_valid_q;
	logic cell_out_q;
	logic out_free;
	logic load_out;

	assign out_free = !m_valid_q || m_tready;
	assign load_out = (state_q == ST_DONE) && out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_op)
						OP_WRITE, OP_READ: state_d = ST_CELL;
						OP_ADVANCE:        state_d = (n_act == '0) ? ST_DONE : ST_GEN_TOP;
						OP_CLEAR:          state_d = ST_DONE;
						default:           state_d = ST_DONE;
					endcase
				end
			end
			ST_CELL:    state_d = ST_DONE;
			ST_GEN_TOP: state_d = ST_GEN_MID;
			ST_GEN_MID: state_d = ST_GEN_ROW;
			ST_GEN_ROW: begin
				if (last_row) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory control and handshake outputs.
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		mem_we   = 1'b0;
		wr_addr  = row_q;
		wr_data  = new_row;
		clr_all  = size_wr;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					unique case (in_op)
						OP_WRITE, OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = AW'(in_row);
						end
						OP_ADVANCE: begin
							rd_en   = 1'b1;
							rd_addr = n_m1[AW-1:0];
						end
						OP_CLEAR: clr_all = 1'b1;
						default: ;
					endcase
				end
			end
			ST_CELL: begin
				mem_we           = (op_q == OP_WRITE) && hit_q;
				wr_data          = rd_row;
				wr_data[col_q]   = cell_in_q;
			end
			ST_GEN_TOP: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			ST_GEN_MID: begin
				// Row 1 is the lower neighbour of row 0 whenever the grid has one.
				rd_en   = (n_act > NW'(1));
				rd_addr = AW'(1);
			end
			ST_GEN_ROW: begin
				mem_we  = 1'b1;
				rd_en   = more_rows;
				rd_addr = row_q + AW'(2);
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_out) begin
			cell_out_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q      <= in_op;
					col_q     <= AW'(in_col);
					row_q     <= AW'(in_row);
					cell_in_q <= in_cell;
					hit_q     <= in_hit;
					res_q     <= 1'b0;
				end
			end
			ST_CELL: begin
				res_q <= (op_q == OP_READ) && hit_q && rd_row[col_q];
			end
			ST_GEN_TOP: begin
				up_q <= wrap_q ? rd_row : '0;
			end
			ST_GEN_MID: begin
				mid_q   <= rd_row;
				first_q <= rd_row;
				row_q   <= '0;
			end
			ST_GEN_ROW: begin
				up_q  <= mid_q;
				mid_q <= dn_row;
				row_q <= row_q + AW'(1);
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'(cell_out_q);

	// Checks.
	`LGS_ASSERT_IMPL(a_no_write_idle, state_q == ST_IDLE, !mem_we)
	`LGS_ASSERT_IMPL(a_gen_row_in_grid, state_q == ST_GEN_ROW, NW'(row_q) < n_act)
	`LGS_ASSERT_NEXT(a_done_loads_out, load_out, m_tvalid)
	`LGS_ASSERT_NEXT(a_clear_empties, in_acc && (in_op == OP_CLEAR), vld_q == '0)

endmodule

// ===== rtl/lgs_row_next.sv =====
module lgs_row_next #(
	parameter int MAX_SIZE = lgs_pkg::MAX_SIZE_DEF
) (
	input  logic [MAX_SIZE-1:0]            up,
	input  logic [MAX_SIZE-1:0]            mid,
	input  logic [MAX_SIZE-1:0]            dn,
	input  logic [$clog2(MAX_SIZE+1)-1:0]  size,
	input  logic                           wrap,
	output logic [MAX_SIZE-1:0]            nxt
);
	import lgs_pkg::*;

	localparam int NW = $clog2(MAX_SIZE + 1);
	localparam int AW = $clog2(MAX_SIZE);
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	logic [NW-1:0] last_idx;
	logic          up_last, mid_last, dn_last;
	logic          up_first, mid_first, dn_first;

	// The wrapped neighbours of the edge columns, shared by the whole row.
	assign last_idx  = size - NW'(1);
	assign up_last   = wrap & up[last_idx[AW-1:0]];
	assign mid_last  = wrap & mid[last_idx[AW-1:0]];
	assign dn_last   = wrap & dn[last_idx[AW-1:0]];
	assign up_first  = wrap & up[0];
	assign mid_first = wrap & mid[0];
	assign dn_first  = wrap & dn[0];

	for (genvar c = 0; c < MAX_SIZE; c++) begin : g_col
		logic       ul, ml, dl, ur, mr, dr;
		logic       right_edge;
		logic [3:0] k;

		if (c == 0) begin : g_left_edge
			assign ul = up_last;
			assign ml = mid_last;
			assign dl = dn_last;
		end else begin : g_left_in
			assign ul = up[c-1];
			assign ml = mid[c-1];
			assign dl = dn[c-1];
		end

		assign right_edge = (last_idx == NW'(c));

		if (c == MAX_SIZE - 1) begin : g_right_edge
			assign ur = up_first;
			assign mr = mid_first;
			assign dr = dn_first;
		end else begin : g_right_in
			assign ur = right_edge ? up_first  : up[c+1];
			assign mr = right_edge ? mid_first : mid[c+1];
			assign dr = right_edge ? dn_first  : dn[c+1];
		end

		assign k = 4'(ul) + 4'(up[c]) + 4'(ur) + 4'(ml) + 4'(mr)
			+ 4'(dl) + 4'(dn[c]) + 4'(dr);
		assign nxt[c] = (k == BIRTH_COUNT) || (mid[c] && (k == SURVIVE_COUNT));
	end

endmodule
